FILE: hdl/spqa_pkg.sv
package spqa_pkg;

    // default sizing
    localparam int unsigned LEVELS_DEF       = 4;
    localparam int unsigned DEPTH_DEF        = 64;
    localparam int unsigned CATEGORIES_DEF   = 4;
    localparam int unsigned PAYLOAD_BITS_DEF = 32;

    // register file: seven 32-bit registers at 4-byte stride
    localparam int unsigned CFG_AW = 5;

    localparam logic [2:0] REG_MAX_ITEMS = 3'd0;
    localparam logic [2:0] REG_THRESH    = 3'd1;
    localparam logic [2:0] REG_LIM_EN    = 3'd2;
    localparam logic [2:0] REG_LIM0      = 3'd3;
    localparam logic [2:0] REG_LIM1      = 3'd4;
    localparam logic [2:0] REG_LIM2      = 3'd5;
    localparam logic [2:0] REG_LIM3      = 3'd6;

    localparam logic [8:0] MAX_ITEMS_RST = 9'd256;
    localparam logic [8:0] THRESH_RST    = 9'd205;
    localparam logic [8:0] LIM_RST       = 9'd256;
    // 1.0 in Q1.8
    localparam logic [8:0] Q_ONE         = 9'd256;

    // operation codes
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    // refusal reasons
    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_PRESS = 3'd1;
    localparam logic [2:0] RSN_CAT   = 3'd2;
    localparam logic [2:0] RSN_MAX   = 3'd3;
    localparam logic [2:0] RSN_FULL  = 3'd4;

    typedef struct packed {
        logic [8:0]      max_items;
        logic [8:0]      thresh;
        logic [3:0]      lim_en;
        logic [3:0][8:0] lim;
    } t_cfg;

endpackage

FILE: hdl/spqa_if.sv
interface spqa_req_if #(
    parameter int unsigned PAYLOAD_BITS = spqa_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [1:0]              level;
    logic [1:0]              category;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, operation, level, category, payload, input ready);
    modport sink   (input valid, operation, level, category, payload, output ready);
endinterface

interface spqa_rsp_if #(
    parameter int unsigned PAYLOAD_BITS = spqa_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    accepted;
    logic [2:0]              refuse_reason;
    logic                    out_valid;
    logic [1:0]              out_level;
    logic [1:0]              out_category;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [8:0]              total_items;
    logic                    pressure_active;

    modport source (output valid, accepted, refuse_reason, out_valid, out_level,
                    out_category, out_payload, total_items, pressure_active,
                    input ready);
    modport sink   (input valid, accepted, refuse_reason, out_valid, out_level,
                    out_category, out_payload, total_items, pressure_active,
                    output ready);
endinterface

FILE: hdl/strict_priority_queue_admission_top.sv
// Strict priority queue with admission control.
// i_req (valid/ready) carries one operation word: enqueue, dequeue or clear.
// o_rsp (valid/ready) returns exactly one result word for each request word:
// admission outcome, the dequeued entry, the total and the back pressure flag.
// The APB port writes and reads the seven configuration registers; pready is
// tied high. Write configuration only while no request is in flight.
// Enqueue, clear, unused codes and an empty dequeue: the result is registered
// at the accept edge. A dequeue that finds an entry passes through ST_RD, and
// its result is registered from the registered read of the entry memory.
// Sustained rate: one word per cycle, except in ST_RD or a receiver stall.
// The result register lets a new word in while the previous result is being
// taken in the same cycle; while the receiver stalls with a result held,
// i_req.ready stays low and nothing is lost.
// Reset (synchronous, active low) empties all levels, zeroes the counts,
// clears back pressure and loads the register defaults. The entry memory
// needs no clearing pass: a slot is only read after it has been written.
module strict_priority_queue_admission_top #(
    parameter int unsigned LEVELS       = spqa_pkg::LEVELS_DEF,
    parameter int unsigned DEPTH        = spqa_pkg::DEPTH_DEF,
    parameter int unsigned CATEGORIES   = spqa_pkg::CATEGORIES_DEF,
    parameter int unsigned PAYLOAD_BITS = spqa_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spqa_req_if.sink                    i_req,
    spqa_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spqa_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import spqa_pkg::*;

    localparam int unsigned LW    = $clog2(LEVELS);
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned SLOTS = 1 << PW;
    localparam int unsigned CNTW  = $clog2(DEPTH + 1);
    localparam int unsigned TOTW  = $clog2(LEVELS * DEPTH + 1);
    localparam int unsigned CATW  = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int unsigned RAMW  = PAYLOAD_BITS + 2;
    localparam int unsigned RAMD  = LEVELS * SLOTS;
    localparam int unsigned AW    = LW + PW;

    typedef enum logic {ST_IDLE, ST_RD} t_state;

    t_cfg w_cfg;

    // control state
    t_state              r_state,  n_state;
    logic [PW-1:0]       r_head   [LEVELS];
    logic [PW-1:0]       n_head   [LEVELS];
    logic [PW-1:0]       r_tail   [LEVELS];
    logic [PW-1:0]       n_tail   [LEVELS];
    logic [CNTW-1:0]     r_lcnt   [LEVELS];
    logic [CNTW-1:0]     n_lcnt   [LEVELS];
    logic [TOTW-1:0]     r_ccnt   [CATEGORIES];
    logic [TOTW-1:0]     n_ccnt   [CATEGORIES];
    logic [TOTW-1:0]     r_total,  n_total;
    logic                r_press,  n_press;
    logic                r_ovalid, n_ovalid;

    // result word and pending dequeue level
    logic [LW-1:0]           r_dq_lvl,  n_dq_lvl;
    logic                    r_acc,     n_acc;
    logic [2:0]              r_rsn,     n_rsn;
    logic                    r_oval,    n_oval;
    logic [1:0]              r_olvl,    n_olvl;
    logic [1:0]              r_ocat,    n_ocat;
    logic [PAYLOAD_BITS-1:0] r_opay,    n_opay;
    logic [8:0]              r_ototal,  n_ototal;
    logic                    r_opress,  n_opress;

    // request decode
    logic            w_acc_in;
    logic [LW-1:0]   w_lvl;
    logic [CATW-1:0] w_cat;
    logic            w_crit;
    logic [2:0]      w_rsn;
    logic            w_hit;
    logic [LW-1:0]   w_sel;
    logic [8:0]      w_thr;
    logic [17:0]     w_rhs;

    // memory port
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [RAMW-1:0] w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic [RAMW-1:0] w_rdata;
    logic [1:0]      w_rcat_raw;
    logic [CATW-1:0] w_rcat;

    spqa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // entry memory, one region of SLOTS entries per level
    spqa_ram #(
        .WIDTH (RAMW),
        .DEPTH (RAMD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE) && (!r_ovalid || o_rsp.ready);
    assign w_acc_in    = i_req.valid && i_req.ready;

    // out-of-range level/category saturate to the top index
    assign w_lvl  = (32'(i_req.level) >= LEVELS) ? LW'(LEVELS - 1) : LW'(i_req.level);
    assign w_cat  = (32'(i_req.category) >= CATEGORIES) ?
                    CATW'(CATEGORIES - 1) : CATW'(i_req.category);
    assign w_crit = (w_lvl == '0);

    always_comb begin
        if (!w_crit && r_press) begin
            w_rsn = RSN_PRESS;
        end else if (!w_crit && w_cfg.lim_en[w_cat] &&
                     32'(r_ccnt[w_cat]) >= 32'(w_cfg.lim[w_cat])) begin
            w_rsn = RSN_CAT;
        end else if (!w_crit && 32'(r_total) >= 32'(w_cfg.max_items)) begin
            w_rsn = RSN_MAX;
        end else if (32'(r_lcnt[w_lvl]) >= DEPTH) begin
            w_rsn = RSN_FULL;
        end else begin
            w_rsn = RSN_NONE;
        end
    end

    // lowest non-empty level
    always_comb begin
        w_hit = 1'b0;
        w_sel = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_lcnt[l] != '0) begin
                w_hit = 1'b1;
                w_sel = LW'(l);
            end
        end
    end

    assign w_we    = w_acc_in && (i_req.operation == OP_ENQ) && (w_rsn == RSN_NONE);
    assign w_waddr = {w_lvl, r_tail[w_lvl]};
    assign w_wdata = {2'(w_cat), i_req.payload};
    assign w_re    = w_acc_in && (i_req.operation == OP_DEQ) && w_hit;
    assign w_raddr = {w_sel, r_head[w_sel]};

    assign w_rcat_raw = w_rdata[PAYLOAD_BITS +: 2];
    assign w_rcat     = (32'(w_rcat_raw) >= CATEGORIES) ?
                        CATW'(CATEGORIES - 1) : CATW'(w_rcat_raw);

    // threshold clamped to 1.0, times max_items
    assign w_thr = (w_cfg.thresh > Q_ONE) ? Q_ONE : w_cfg.thresh;
    assign w_rhs = 18'(w_thr) * 18'(w_cfg.max_items);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_lcnt   = r_lcnt;
        n_ccnt   = r_ccnt;
        n_total  = r_total;
        n_press  = r_press;
        n_ovalid = r_ovalid;
        n_dq_lvl = r_dq_lvl;
        n_acc    = r_acc;
        n_rsn    = r_rsn;
        n_oval   = r_oval;
        n_olvl   = r_olvl;
        n_ocat   = r_ocat;
        n_opay   = r_opay;
        n_ototal = r_ototal;
        n_opress = r_opress;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    n_acc    = 1'b0;
                    n_rsn    = RSN_NONE;
                    n_oval   = 1'b0;
                    n_olvl   = '0;
                    n_ocat   = '0;
                    n_opay   = '0;
                    case (i_req.operation)
                        OP_ENQ: begin
                            n_ovalid = 1'b1;
                            n_rsn    = w_rsn;
                            if (w_rsn == RSN_NONE) begin
                                n_acc         = 1'b1;
                                n_tail[w_lvl] = (r_tail[w_lvl] == PW'(DEPTH - 1)) ?
                                                '0 : r_tail[w_lvl] + 1'b1;
                                n_lcnt[w_lvl] = r_lcnt[w_lvl] + 1'b1;
                                n_ccnt[w_cat] = r_ccnt[w_cat] + 1'b1;
                                n_total       = r_total + 1'b1;
                            end
                        end
                        OP_DEQ: begin
                            if (w_hit) begin
                                // result formed once the entry is read back
                                n_state       = ST_RD;
                                n_dq_lvl      = w_sel;
                                n_head[w_sel] = (r_head[w_sel] == PW'(DEPTH - 1)) ?
                                                '0 : r_head[w_sel] + 1'b1;
                                n_lcnt[w_sel] = r_lcnt[w_sel] - 1'b1;
                            end else begin
                                n_ovalid = 1'b1;
                            end
                        end
                        OP_CLR: begin
                            n_ovalid = 1'b1;
                            n_head   = '{default: '0};
                            n_tail   = '{default: '0};
                            n_lcnt   = '{default: '0};
                            n_ccnt   = '{default: '0};
                            n_total  = '0;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                    n_ototal = 9'(n_total);
                    n_opress = r_press;
                end
            end
            ST_RD: begin
                n_state  = ST_IDLE;
                n_total  = r_total - 1'b1;
                if (r_ccnt[w_rcat] != '0) begin
                    n_ccnt[w_rcat] = r_ccnt[w_rcat] - 1'b1;
                end
                n_press  = (32'({n_total, 8'd0}) >= 32'(w_rhs));
                n_ovalid = 1'b1;
                n_acc    = 1'b0;
                n_rsn    = RSN_NONE;
                n_oval   = 1'b1;
                n_olvl   = 2'(r_dq_lvl);
                n_ocat   = 2'(w_rcat);
                n_opay   = w_rdata[PAYLOAD_BITS-1:0];
                n_ototal = 9'(n_total);
                n_opress = n_press;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '{default: '0};
            r_tail   <= '{default: '0};
            r_lcnt   <= '{default: '0};
            r_ccnt   <= '{default: '0};
            r_total  <= '0;
            r_press  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_lcnt   <= n_lcnt;
            r_ccnt   <= n_ccnt;
            r_total  <= n_total;
            r_press  <= n_press;
            r_ovalid <= n_ovalid;
        end
        r_dq_lvl <= n_dq_lvl;
        r_acc    <= n_acc;
        r_rsn    <= n_rsn;
        r_oval   <= n_oval;
        r_olvl   <= n_olvl;
        r_ocat   <= n_ocat;
        r_opay   <= n_opay;
        r_ototal <= n_ototal;
        r_opress <= n_opress;
    end

    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.accepted        = r_acc;
    assign o_rsp.refuse_reason   = r_rsn;
    assign o_rsp.out_valid       = r_oval;
    assign o_rsp.out_level       = r_olvl;
    assign o_rsp.out_category    = r_ocat;
    assign o_rsp.out_payload     = r_opay;
    assign o_rsp.total_items     = r_ototal;
    assign o_rsp.pressure_active = r_opress;

`ifndef NO_ASSERTIONS
    // the result register is always free while a read is outstanding
    a_rd_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> !r_ovalid)
        else $error("result register busy during entry read");

    // a stored enqueue bumps the total by one
    a_enq_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_req.operation == OP_ENQ && w_rsn == RSN_NONE)
        |=> (r_total == $past(r_total) + 1'b1))
        else $error("total not incremented on stored enqueue");

    // back pressure moves only when a dequeue completes
    a_press_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_press != $past(r_press)) |-> ($past(r_state) == ST_RD))
        else $error("back pressure changed outside a dequeue");

    // the read-back cycle always presents a dequeued entry
    a_rd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |=> (r_ovalid && r_oval && !r_acc))
        else $error("dequeue result missing after entry read");
`endif

endmodule

FILE: hdl/spqa_ram.sv
module spqa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/spqa_cfg.sv
module spqa_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spqa_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output spqa_pkg::t_cfg              o_cfg
);
    import spqa_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_items <= MAX_ITEMS_RST;
            r_cfg.thresh    <= THRESH_RST;
            r_cfg.lim_en    <= '0;
            r_cfg.lim       <= {4{LIM_RST}};
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_MAX_ITEMS: r_cfg.max_items <= pwdata[8:0];
                REG_THRESH:    r_cfg.thresh    <= pwdata[8:0];
                REG_LIM_EN:    r_cfg.lim_en    <= pwdata[3:0];
                REG_LIM0:      r_cfg.lim[0]    <= pwdata[8:0];
                REG_LIM1:      r_cfg.lim[1]    <= pwdata[8:0];
                REG_LIM2:      r_cfg.lim[2]    <= pwdata[8:0];
                REG_LIM3:      r_cfg.lim[3]    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAX_ITEMS: prdata = {23'd0, r_cfg.max_items};
            REG_THRESH:    prdata = {23'd0, r_cfg.thresh};
            REG_LIM_EN:    prdata = {28'd0, r_cfg.lim_en};
            REG_LIM0:      prdata = {23'd0, r_cfg.lim[0]};
            REG_LIM1:      prdata = {23'd0, r_cfg.lim[1]};
            REG_LIM2:      prdata = {23'd0, r_cfg.lim[2]};
            REG_LIM3:      prdata = {23'd0, r_cfg.lim[3]};
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: test/strict_priority_queue_admission_top_tb.sv
module strict_priority_queue_admission_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spqa_pkg::*;

    localparam int unsigned NLVL        = LEVELS_DEF;
    localparam int unsigned NSLOT       = DEPTH_DEF;
    localparam int unsigned NCAT        = CATEGORIES_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [1:0]  OP_NOP      = 2'd3;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  reason;
        logic        hit;
        logic [1:0]  lvl;
        logic [1:0]  cat;
        logic [31:0] payload;
        logic [8:0]  total;
        logic        pressure;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spqa_req_if #(.PAYLOAD_BITS(32)) req_bus ();
    spqa_rsp_if #(.PAYLOAD_BITS(32)) rsp_bus ();

    strict_priority_queue_admission_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the queue state
    logic [31:0] slot_payload [NLVL][NSLOT];
    logic [1:0]  slot_cat [NLVL][NSLOT];
    int unsigned head_ptr [NLVL];
    int unsigned tail_ptr [NLVL];
    int unsigned fill [NLVL];
    int unsigned cat_count [NCAT];
    int unsigned queued_total;
    logic        backpressure;
    t_cfg        cfg_model;

    t_result     expected_results [$];
    int unsigned fault_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold = 0;
    int unsigned burst_left = 0;
    int unsigned gap_next = 0;

    function automatic void empty_queues();
        for (int l = 0; l < NLVL; l++) begin
            head_ptr[l] = 0;
            tail_ptr[l] = 0;
            fill[l] = 0;
        end
        for (int c = 0; c < NCAT; c++) cat_count[c] = 0;
        queued_total = 0;
    endfunction

    function automatic t_result queue_outcome(input logic [1:0] op, input logic [1:0] lvl,
                                              input logic [1:0] cat, input logic [31:0] pay);
        t_result r;
        int unsigned thr;
        logic [1:0] c;
        r = '0;
        case (op)
            OP_ENQ: begin
                if (lvl != 0 && backpressure) begin
                    r.reason = RSN_PRESS;
                end else if (lvl != 0 && cfg_model.lim_en[cat] &&
                             cat_count[cat] >= cfg_model.lim[cat]) begin
                    r.reason = RSN_CAT;
                end else if (lvl != 0 && queued_total >= cfg_model.max_items) begin
                    r.reason = RSN_MAX;
                end else if (fill[lvl] >= NSLOT) begin
                    r.reason = RSN_FULL;
                end else begin
                    slot_payload[lvl][tail_ptr[lvl]] = pay;
                    slot_cat[lvl][tail_ptr[lvl]] = cat;
                    tail_ptr[lvl] = (tail_ptr[lvl] + 1) % NSLOT;
                    fill[lvl]++;
                    queued_total++;
                    cat_count[cat]++;
                    r.accepted = 1'b1;
                end
            end
            OP_DEQ: begin
                for (int l = 0; l < NLVL; l++) begin
                    if (!r.hit && fill[l] != 0) begin
                        c = slot_cat[l][head_ptr[l]];
                        r.hit = 1'b1;
                        r.lvl = l[1:0];
                        r.cat = c;
                        r.payload = slot_payload[l][head_ptr[l]];
                        head_ptr[l] = (head_ptr[l] + 1) % NSLOT;
                        fill[l]--;
                        queued_total--;
                        if (cat_count[c] > 0) cat_count[c]--;
                        // threshold is Q1.8, anything above 1.0 clamps
                        thr = 32'((cfg_model.thresh > Q_ONE) ? Q_ONE : cfg_model.thresh);
                        backpressure = (queued_total * 256 >= thr * cfg_model.max_items);
                    end
                end
            end
            OP_CLR: empty_queues();
            default: ;
        endcase
        r.total = queued_total[8:0];
        r.pressure = backpressure;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("acc=%0d rsn=%0d hit=%0d lvl=%0d cat=%0d pay=%h total=%0d bp=%0d",
                         r.accepted, r.reason, r.hit, r.lvl, r.cat, r.payload, r.total,
                         r.pressure);
    endfunction

    function automatic t_cfg make_cfg(input logic [8:0] max_items, input logic [8:0] thresh,
                                      input logic [3:0] lim_en, input logic [8:0] l0,
                                      input logic [8:0] l1, input logic [8:0] l2,
                                      input logic [8:0] l3);
        t_cfg c;
        c.max_items = max_items;
        c.thresh = thresh;
        c.lim_en = lim_en;
        c.lim[0] = l0;
        c.lim[1] = l1;
        c.lim[2] = l2;
        c.lim[3] = l3;
        return c;
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    // one word per call; a gap may be inserted after the last word of a burst
    task automatic push_word(input logic [1:0] op, input logic [1:0] lvl,
                             input logic [1:0] cat, input logic [31:0] pay);
        if (gap_next != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap_next) @(posedge i_clk);
            gap_next = 0;
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.level     <= lvl;
        req_bus.category  <= cat;
        req_bus.payload   <= pay;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        expected_results.push_back(queue_outcome(op, lvl, cat, pay));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap_next = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        gap_next = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_MAX_ITEMS: cfg_model.max_items = value;
            REG_THRESH:    cfg_model.thresh = value;
            REG_LIM_EN:    cfg_model.lim_en = value[3:0];
            REG_LIM0:      cfg_model.lim[0] = value;
            REG_LIM1:      cfg_model.lim[1] = value;
            REG_LIM2:      cfg_model.lim[2] = value;
            REG_LIM3:      cfg_model.lim[3] = value;
            default: ;
        endcase
    endtask

    // only called with the block idle
    task automatic load_config(input t_cfg c);
        write_reg(REG_MAX_ITEMS, c.max_items);
        write_reg(REG_THRESH, c.thresh);
        write_reg(REG_LIM_EN, {5'd0, c.lim_en});
        write_reg(REG_LIM0, c.lim[0]);
        write_reg(REG_LIM1, c.lim[1]);
        write_reg(REG_LIM2, c.lim[2]);
        write_reg(REG_LIM3, c.lim[3]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_basic_ops();
        load_config(make_cfg(MAX_ITEMS_RST, THRESH_RST, 4'h0, LIM_RST, LIM_RST, LIM_RST,
                             LIM_RST));
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
        push_word(OP_NOP, 2'd3, 2'd3, 32'hFFFF_FFFF);
        push_word(OP_ENQ, 2'd3, 2'd0, 32'h0000_0000);
        push_word(OP_ENQ, 2'd2, 2'd1, 32'hFFFF_FFFF);
        push_word(OP_ENQ, 2'd1, 2'd2, 32'h5555_5555);
        push_word(OP_ENQ, 2'd0, 2'd3, 32'hAAAA_AAAA);
        push_word(OP_ENQ, 2'd3, 2'd3, 32'h8000_0001);
        // strict order: level 0 first, then oldest within a level
        repeat (6) push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
        push_word(OP_ENQ, 2'd1, 2'd1, 32'h1234_5678);
        push_word(OP_ENQ, 2'd2, 2'd2, 32'h9ABC_DEF0);
        push_word(OP_CLR, 2'd0, 2'd0, 32'd0);
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
    endtask

    task automatic test_admission_rules();
        settle();
        load_config(make_cfg(9'd3, THRESH_RST, 4'b0010, LIM_RST, 9'd1, LIM_RST, LIM_RST));
        push_word(OP_ENQ, 2'd1, 2'd1, $urandom());
        push_word(OP_ENQ, 2'd2, 2'd1, $urandom());   // category limit
        push_word(OP_ENQ, 2'd1, 2'd0, $urandom());
        push_word(OP_ENQ, 2'd3, 2'd2, $urandom());
        push_word(OP_ENQ, 2'd2, 2'd3, $urandom());   // total at max
        push_word(OP_ENQ, 2'd0, 2'd1, $urandom());   // critical goes above max
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);        // raises back pressure
        push_word(OP_ENQ, 2'd1, 2'd0, $urandom());
        push_word(OP_CLR, 2'd0, 2'd0, 32'd0);        // flag survives a clear
        push_word(OP_ENQ, 2'd2, 2'd2, $urandom());
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
        push_word(OP_ENQ, 2'd0, 2'd3, $urandom());
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
        settle();
        // zero max items: the flag sets on any hit; threshold above 1.0 clamps
        load_config(make_cfg(9'd0, 9'd300, 4'h0, LIM_RST, LIM_RST, LIM_RST, LIM_RST));
        push_word(OP_ENQ, 2'd0, 2'd2, $urandom());
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
        push_word(OP_ENQ, 2'd3, 2'd1, $urandom());
        settle();
        load_config(make_cfg(MAX_ITEMS_RST, THRESH_RST, 4'h0, LIM_RST, LIM_RST, LIM_RST,
                             LIM_RST));
        push_word(OP_ENQ, 2'd0, 2'd0, $urandom());
        push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
    endtask

    task automatic test_level_overflow();
        settle();
        repeat (NSLOT + 1) push_word(OP_ENQ, 2'd3, 2'($urandom_range(0, 3)), $urandom());
        repeat (NSLOT + 1) push_word(OP_ENQ, 2'd0, 2'($urandom_range(0, 3)), $urandom());
        repeat (2 * NSLOT + 1) push_word(OP_DEQ, 2'd0, 2'd0, 32'd0);
    endtask

    task automatic run_phase(input t_cfg c, input int unsigned n_words,
                             input int unsigned enq_pct);
        int unsigned roll;
        logic [1:0] op;
        settle();
        load_config(c);
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 2 && $urandom_range(0, 1) == 1) settle();
            roll = $urandom_range(0, 99);
            if (roll < 1) op = OP_CLR;
            else if (roll < 3) op = OP_NOP;
            else if (roll < 3 + enq_pct) op = OP_ENQ;
            else op = OP_DEQ;
            push_word(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom());
        end
    endtask

    task automatic test_random_traffic();
        run_phase(make_cfg(MAX_ITEMS_RST, THRESH_RST, 4'h0, LIM_RST, LIM_RST, LIM_RST,
                           LIM_RST), 90, 60);
        run_phase(make_cfg(9'd0, 9'd0, 4'hF, 9'd0, 9'd0, 9'd0, 9'd0), 70, 60);
        run_phase(make_cfg(9'd511, 9'd511, 4'hF, 9'd511, 9'd511, 9'd511, 9'd511), 100, 80);
        run_phase(make_cfg(9'd40, 9'd300, 4'b0101, 9'd5, 9'd256, 9'd10, 9'd0), 90, 65);
        run_phase(make_cfg(9'd100, 9'd128, 4'b1010, 9'd511, 9'd20, 9'd0, 9'd30), 90, 70);
        run_phase(make_cfg(9'd256, 9'd256, 4'h0, LIM_RST, LIM_RST, LIM_RST, LIM_RST), 90, 85);
        run_phase(make_cfg(9'($urandom_range(1, 256)), 9'($urandom_range(0, 511)),
                           4'($urandom_range(0, 15)), 9'($urandom_range(0, 300)),
                           9'($urandom_range(0, 300)), 9'($urandom_range(0, 300)),
                           9'($urandom_range(0, 300))), 90, 65);
    endtask

    // receiver: random stalls, with stall-free stretches while bit 9 of the cycle count is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (!cycle_count[9] && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            sink_hold <= $urandom_range(0, 5);
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.accepted = rsp_bus.accepted;
            got.reason   = rsp_bus.refuse_reason;
            got.hit      = rsp_bus.out_valid;
            got.lvl      = rsp_bus.out_level;
            got.cat      = rsp_bus.out_category;
            got.payload  = rsp_bus.out_payload;
            got.total    = rsp_bus.total_items;
            got.pressure = rsp_bus.pressure_active;
            if (expected_results.size() == 0) begin
                log_fault({"unexpected word: ", show(got)});
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    log_fault({"mismatch: exp ", show(want), " got ", show(got)});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_bus.valid     = 1'b0;
        req_bus.operation = OP_ENQ;
        req_bus.level     = 2'd0;
        req_bus.category  = 2'd0;
        req_bus.payload   = '0;
        empty_queues();
        backpressure = 1'b0;
        cfg_model = make_cfg(MAX_ITEMS_RST, THRESH_RST, 4'h0, LIM_RST, LIM_RST, LIM_RST,
                             LIM_RST);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_admission_rules();
        test_level_overflow();
        test_random_traffic();
        settle();

        if (expected_results.size() != 0)
            log_fault($sformatf("%0d words never returned", expected_results.size()));
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
